// ===== design/mvm_pkg.sv =====
// mvm_pkg: shared types and constants for the matrix-vector multiply unit
// item opcodes, register indexes, work queue entry and back-end status
// no dependencies
package mvm_pkg;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MATRIX = 1'b1;

    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    // one matrix element with its vector operand and row tags
    typedef struct packed {
        logic signed [31:0] mat_val;
        logic signed [31:0] vec_val;
        logic               first;
        logic               row_end;
        logic               last;
        logic [11:0]        row_index;
    } t_work;

    typedef struct packed {
        logic mul_valid;
        logic mul_end;
        logic adv;
    } t_back_stat;

endpackage

// ===== design/mvm_ram.sv =====
// mvm_ram: generic single write port, single read port RAM
// registered read data, no reset; no dependencies
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mvm_queue.sv =====
// mvm_queue: short work queue between the front and back ends
// depends on mvm_pkg (t_work, Q_DEPTH)
module mvm_queue import mvm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_work              i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output t_work              o_data,
    output logic [Q_CNT_W-1:0] o_count
);

    t_work              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_pop;

    // front only pushes when a slot is reserved for it
    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

// ===== design/mvm_front.sv =====
// mvm_front: input handshake, vector store, column and row counters
// classifies items, reads x for each matrix element and pushes work entries
// depends on mvm_pkg and mvm_ram
module mvm_front import mvm_pkg::*; #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096,
    localparam int AW = $clog2(MAX_COLS),
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic [11:0]        i_vec_index,
    input  logic signed [31:0] i_value,
    input  logic [12:0]        i_cols,
    input  logic [12:0]        i_rows,
    input  logic [Q_CNT_W-1:0] i_q_count,
    output logic               o_push,
    output t_work              o_work
);

    logic [AW-1:0]    r_col;
    logic [AW-1:0]    n_col;
    logic [RW-1:0]    r_row;
    logic [RW-1:0]    n_row;
    logic             r_s1_valid;
    t_work            r_s1;
    logic [31:0]      w_rdata;
    logic [Q_CNT_W:0] w_inflight;
    logic             w_accept;
    logic             w_load;
    logic             w_mat;
    logic             w_col_end;
    logic             w_row_last;
    logic             w_idx_ok;

    // queue entries plus the one in the read stage must fit the queue
    assign w_inflight = {1'b0, i_q_count} + (Q_CNT_W + 1)'(r_s1_valid);
    assign o_ready    = w_inflight < (Q_CNT_W + 1)'(Q_DEPTH);

    assign w_accept   = i_valid && o_ready;
    assign w_load     = w_accept && (i_opcode == OP_LOAD);
    assign w_mat      = w_accept && (i_opcode == OP_MATRIX);
    assign w_col_end  = (17'(r_col) + 17'd1) >= 17'(i_cols);
    assign w_row_last = (17'(r_row) + 17'd1) >= 17'(i_rows);
    assign w_idx_ok   = 17'(i_vec_index) < 17'(MAX_COLS);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_load) begin
            n_col = '0;
            n_row = '0;
        end else if (w_mat) begin
            if (w_col_end) begin
                n_col = '0;
                n_row = w_row_last ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= w_mat;
        end
    end

    // tags wait here for the registered store read
    always_ff @(posedge i_clk) begin
        if (w_mat) begin
            r_s1.mat_val   <= i_value;
            r_s1.vec_val   <= '0;
            r_s1.first     <= (r_col == '0);
            r_s1.row_end   <= w_col_end;
            r_s1.last      <= w_row_last;
            r_s1.row_index <= 12'(r_row);
        end
    end

    mvm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLS)
    ) u_vec_store (
        .i_clk   (i_clk),
        .i_we    (w_load && w_idx_ok),
        .i_waddr (AW'(i_vec_index)),
        .i_wdata (i_value),
        .i_re    (w_mat),
        .i_raddr (r_col),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_work         = r_s1;
        o_work.vec_val = w_rdata;
    end

    assign o_push = r_s1_valid;

endmodule

// ===== design/mvm_back.sv =====
// mvm_back: multiply, saturating accumulate and output register
// pops work entries and emits one transfer per completed row
// depends on mvm_pkg
module mvm_back import mvm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_work              i_q_data,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_row_sum,
    output logic [11:0]        o_row_index,
    output logic               o_last_row,
    output logic               o_saturated,
    output t_back_stat         o_stat
);

    logic               r_mul_valid;
    logic signed [63:0] r_mul_prod;
    logic               r_mul_first;
    logic               r_mul_end;
    logic               r_mul_last;
    logic [11:0]        r_mul_row;
    logic signed [63:0] r_acc;
    logic               r_clip;
    logic               r_out_valid;
    logic signed [63:0] r_out_sum;
    logic [11:0]        r_out_row;
    logic               r_out_last;
    logic               r_out_sat;

    logic               w_adv;
    logic               w_fire;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_base;
    logic               w_base_clip;
    logic signed [63:0] w_sum;
    logic               w_ovf;
    logic signed [63:0] w_sat;
    logic               w_clip;

    // whole back end holds while a finished row waits to be taken
    assign w_adv  = !r_out_valid || i_ready;
    assign w_fire = w_adv && r_mul_valid;
    assign o_pop  = w_adv && i_q_valid;

    assign w_prod = $signed(i_q_data.mat_val) * $signed(i_q_data.vec_val);

    always_comb begin
        w_base      = r_mul_first ? 64'sd0 : r_acc;
        w_base_clip = r_mul_first ? 1'b0 : r_clip;
        w_sum       = w_base + r_mul_prod;
        w_ovf       = (w_base[63] == r_mul_prod[63]) && (w_sum[63] != w_base[63]);
        if (w_ovf) begin
            w_sat = w_base[63] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sat = w_sum;
        end
        w_clip = w_base_clip || w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_mul_valid <= i_q_valid;
            end
            if (w_fire && r_mul_end) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mul_prod  <= w_prod;
            r_mul_first <= i_q_data.first;
            r_mul_end   <= i_q_data.row_end;
            r_mul_last  <= i_q_data.last;
            r_mul_row   <= i_q_data.row_index;
        end
        if (w_fire) begin
            r_acc  <= w_sat;
            r_clip <= w_clip;
            if (r_mul_end) begin
                r_out_sum  <= w_sat;
                r_out_row  <= r_mul_row;
                r_out_last <= r_mul_last;
                r_out_sat  <= w_clip;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_row_sum   = r_out_sum;
    assign o_row_index = r_out_row;
    assign o_last_row  = r_out_last;
    assign o_saturated = r_out_sat;

    assign o_stat.mul_valid = r_mul_valid;
    assign o_stat.mul_end   = r_mul_end;
    assign o_stat.adv       = w_adv;

endmodule

// ===== design/matrix_vector_multiply_unit.sv =====
// matrix_vector_multiply_unit: top level of the fixed-point y = A*x engine
// ties the front end, work queue and back end together, holds the config registers
// depends on mvm_pkg, mvm_front, mvm_queue, mvm_back
//
// Usage:
//   Input channel (i_valid/o_ready): opcode 0 writes value into the vector store at
//   vec_index and restarts the matrix at row 0, column 0; opcode 1 streams one Q16.16
//   element of A in row-major order.
//   Output channel (o_valid/i_ready): one transfer per row, carrying the Q32.32 row sum
//   (saturated), the row index, a last-row flag and a clip flag.
//   Config port: i_cfg_we with i_cfg_idx 0 sets the column count, 1 the row count;
//   zero acts as one and values above the maximum act as the maximum. Write only
//   while no item is in flight.
//   Throughput: one item per clock while results are taken, set by the single multiplier and accumulator.
//   Path: the last element of a row passes the store read stage, the work queue and the
//   multiply register; its sum then lands in the output register and raises o_valid.
//   Reset: counters, valid flags and the queue clear, both counts return to 4096 (capped at
//   the maximum); vector store contents stay undefined until loaded.
//   Stall: while a row result waits, the back end holds and the four-entry queue
//   fills; o_ready drops once the queue and the store read stage hold four entries.
module matrix_vector_multiply_unit import mvm_pkg::*; #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic [11:0]        i_vec_index,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_row_sum,
    output logic [11:0]        o_row_index,
    output logic               o_last_row,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [12:0]        i_cfg_data
);

    localparam int COLS_RST = (MAX_COLS < 4096) ? MAX_COLS : 4096;
    localparam int ROWS_RST = (MAX_ROWS < 4096) ? MAX_ROWS : 4096;

    logic [12:0]        r_cols;
    logic [12:0]        r_rows;
    logic [12:0]        w_cols_clamp;
    logic [12:0]        w_rows_clamp;
    logic               w_push;
    t_work              w_push_data;
    logic               w_q_valid;
    t_work              w_q_data;
    logic [Q_CNT_W-1:0] w_q_count;
    logic               w_pop;
    t_back_stat         w_bstat;

    // counts are clamped once at write time
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cols_clamp = 13'd1;
        end else if (17'(i_cfg_data) > 17'(MAX_COLS)) begin
            w_cols_clamp = 13'(MAX_COLS);
        end else begin
            w_cols_clamp = i_cfg_data;
        end
        if (i_cfg_data == '0) begin
            w_rows_clamp = 13'd1;
        end else if (17'(i_cfg_data) > 17'(MAX_ROWS)) begin
            w_rows_clamp = 13'(MAX_ROWS);
        end else begin
            w_rows_clamp = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 13'(COLS_RST);
            r_rows <= 13'(ROWS_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLS: begin
                    r_cols <= w_cols_clamp;
                end
                CFG_ROWS: begin
                    r_rows <= w_rows_clamp;
                end
                default: begin
                end
            endcase
        end
    end

    mvm_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_vec_index (i_vec_index),
        .i_value     (i_value),
        .i_cols      (r_cols),
        .i_rows      (r_rows),
        .i_q_count   (w_q_count),
        .o_push      (w_push),
        .o_work      (w_push_data)
    );

    mvm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    mvm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_row_sum   (o_row_sum),
        .o_row_index (o_row_index),
        .o_last_row  (o_last_row),
        .o_saturated (o_saturated),
        .o_stat      (w_bstat)
    );

    // the credit check in the front end must keep the queue from overflowing
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> ((w_q_count != Q_CNT_W'(Q_DEPTH)) || w_pop))
        else $error("work queue push while full");

    // a new result only comes from a row-end entry leaving the multiply stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_bstat.mul_valid && w_bstat.mul_end && w_bstat.adv))
        else $error("result raised without a row end");

    // a stalled result must freeze the back end
    a_stall_holds_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !w_pop)
        else $error("queue popped while result stalled");

endmodule

// ===== dv/matrix_vector_multiply_unit_test.sv =====
// matrix_vector_multiply_unit_test: self-checking bench for the y = A*x unit
// a directed stimulus table then randomised phases, rows checked by the table or a predictor
// depends on mvm_pkg and matrix_vector_multiply_unit
`timescale 1ns / 100ps

module matrix_vector_multiply_unit_test;
    import mvm_pkg::*;

    localparam int          VEC_DEPTH    = 4096;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          IDLE_PCT     = 21;
    localparam int          CALM_START   = 1000;
    localparam int          CALM_END     = 1800;
    localparam logic [1:0]  CFG_SPARE_2  = 2'd2;
    localparam logic [1:0]  CFG_SPARE_3  = 2'd3;
    localparam logic [12:0] COUNT_MAX    = 13'd4096;
    localparam logic [12:0] COUNT_ALL1   = 13'h1FFF;
    localparam logic [12:0] WIDE_COLS    = 13'd64;
    localparam logic [12:0] SINGLE_ROWS  = 13'd150;

    typedef struct packed {
        logic signed [63:0] sum;
        logic [11:0]        row;
        logic               last;
        logic               clip;
    } t_row_result;

    typedef enum logic {STEP_REG, STEP_ITEM} t_step_kind;

    typedef struct {
        t_step_kind  kind;
        logic [1:0]  reg_idx;
        logic [12:0] reg_data;
        logic        op;
        logic [11:0] idx;
        logic [31:0] val;
        bit          typed;
        t_row_result want;
    } t_directed_step;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_ready;
    logic               i_opcode    = OP_LOAD;
    logic [11:0]        i_vec_index = '0;
    logic signed [31:0] i_value     = '0;
    logic               o_valid;
    logic               i_ready     = 1'b0;
    logic signed [63:0] o_row_sum;
    logic [11:0]        o_row_index;
    logic               o_last_row;
    logic               o_saturated;
    logic               i_cfg_we    = 1'b0;
    logic [1:0]         i_cfg_idx   = CFG_COLS;
    logic [12:0]        i_cfg_data  = '0;

    matrix_vector_multiply_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_vec_index (i_vec_index),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_row_sum   (o_row_sum),
        .o_row_index (o_row_index),
        .o_last_row  (o_last_row),
        .o_saturated (o_saturated),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [31:0]        vec_mem [VEC_DEPTH];
    bit                 vec_written [VEC_DEPTH];
    logic [11:0]        col_cnt;
    logic [11:0]        row_cnt;
    logic signed [63:0] acc;
    logic               acc_clip;
    logic [12:0]        cols_reg;
    logic [12:0]        rows_reg;

    t_row_result pending_rows [$];
    t_directed_step directed_steps [$];

    int  cycle_no;
    int  fail_count;
    int  loads_sent;
    int  mats_sent;
    int  rows_checked;
    int  rows_clipped;
    wire calm = (cycle_no >= CALM_START) && (cycle_no < CALM_END);

    function automatic logic [12:0] eff_count(input logic [12:0] v);
        if (v == 13'd0) return 13'd1;
        if (v > COUNT_MAX) return COUNT_MAX;
        return v;
    endfunction

    // one item into the predictor; returns 1 when it closes a row
    function automatic bit mvm_predict(input logic op, input logic [11:0] idx,
                                       input logic [31:0] val, output t_row_result res);
        logic [12:0]        cols;
        logic [12:0]        rows;
        logic signed [63:0] mat64;
        logic signed [63:0] vec64;
        logic signed [63:0] prod;
        logic signed [63:0] total;
        logic               last;
        cols = eff_count(cols_reg);
        rows = eff_count(rows_reg);
        res  = '0;
        if (op == OP_LOAD) begin
            vec_mem[idx]     = val;
            vec_written[idx] = 1'b1;
            col_cnt  = '0;
            row_cnt  = '0;
            acc      = '0;
            acc_clip = 1'b0;
            return 1'b0;
        end
        mat64 = $signed(val);
        vec64 = $signed(vec_mem[col_cnt]);
        prod  = mat64 * vec64;
        total = acc + prod;
        if (acc[63] == prod[63] && total[63] != acc[63]) begin
            total    = acc[63] ? SUM_MIN : SUM_MAX;
            acc_clip = 1'b1;
        end
        acc = total;
        if ({1'b0, col_cnt} + 13'd1 < cols) begin
            col_cnt = col_cnt + 12'd1;
            return 1'b0;
        end
        last     = ({1'b0, row_cnt} + 13'd1 >= rows);
        res.sum  = acc;
        res.row  = row_cnt;
        res.last = last;
        res.clip = acc_clip;
        col_cnt  = '0;
        acc      = '0;
        acc_clip = 1'b0;
        row_cnt  = last ? 12'd0 : row_cnt + 12'd1;
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_directed_step reg_step(input logic [1:0] ri, input logic [12:0] rd);
        t_directed_step s;
        s.kind     = STEP_REG;
        s.reg_idx  = ri;
        s.reg_data = rd;
        s.op       = OP_LOAD;
        s.idx      = '0;
        s.val      = '0;
        s.typed    = 1'b0;
        s.want     = '0;
        return s;
    endfunction

    function automatic t_directed_step item_step(input logic op, input logic [11:0] idx,
                                                 input logic [31:0] val);
        t_directed_step s;
        s.kind     = STEP_ITEM;
        s.reg_idx  = CFG_COLS;
        s.reg_data = '0;
        s.op       = op;
        s.idx      = idx;
        s.val      = val;
        s.typed    = 1'b0;
        s.want     = '0;
        return s;
    endfunction

    function automatic t_directed_step want_step(input logic [31:0] val,
                                                 input logic [63:0] sum,
                                                 input logic [11:0] row, input logic last,
                                                 input logic clip);
        t_directed_step s;
        s       = item_step(OP_MATRIX, 12'd0, val);
        s.typed = 1'b1;
        s.want  = '{sum, row, last, clip};
        return s;
    endfunction

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endtask

    // output side: random back-pressure outside the calm window
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_row_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rows.size() == 0) begin
                report("unexpected row", '0, o_row_sum);
            end else begin
                want = pending_rows.pop_front();
                rows_checked++;
                if (want.clip) rows_clipped++;
                if (o_row_sum !== want.sum) report("row_sum", want.sum, o_row_sum);
                if (o_row_index !== want.row) report("row_index", want.row, o_row_index);
                if (o_last_row !== want.last) report("last_row", want.last, o_last_row);
                if (o_saturated !== want.clip) report("saturated", want.clip, o_saturated);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows outstanding",
                     cycle_no, pending_rows.size());
            $display("matrix_vector_multiply_unit verification failed");
            $finish;
        end
    end

    // drive one item, hold it until the transfer, then run the predictor
    task automatic send_item(input logic op, input logic [11:0] idx, input logic [31:0] val,
                             output bit got, output t_row_result res);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_vec_index <= idx;
        i_value     <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op == OP_LOAD) loads_sent++;
        else mats_sent++;
        got = mvm_predict(op, idx, val, res);
    endtask

    task automatic feed(input logic op, input logic [11:0] idx, input logic [31:0] val);
        bit          got;
        t_row_result res;
        send_item(op, idx, val, got, res);
        if (got) pending_rows.push_back(res);
    endtask

    // wait for every row to come out, plus the pipeline depth
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] ri, input logic [12:0] rd);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ri;
        i_cfg_data <= rd;
        @(posedge i_clk);
        if (ri == CFG_COLS) cols_reg = rd;
        else if (ri == CFG_ROWS) rows_reg = rd;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_shape(input logic [12:0] cols, input logic [12:0] rows);
        settle();
        write_reg(CFG_COLS, cols);
        write_reg(CFG_ROWS, rows);
    endtask

    // load where the stream would read an unwritten entry, else mostly matrix elements
    task automatic random_item(input int noise_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < noise_pct) feed(OP_LOAD, 12'($urandom), pick_value());
        else if (!vec_written[col_cnt]) feed(OP_LOAD, col_cnt, pick_value());
        else feed(OP_MATRIX, 12'($urandom), pick_value());
    endtask

    task automatic load_vector(input int len);
        for (int k = 0; k < len; k++) feed(OP_LOAD, 12'(k), pick_value());
    endtask

    initial begin
        t_directed_step s;
        bit             got;
        t_row_result    res;
        int             phase_start;
        logic [12:0]    cols_w;
        logic [12:0]    rows_w;

        col_cnt  = '0;
        row_cnt  = '0;
        acc      = '0;
        acc_clip = 1'b0;
        cols_reg = COUNT_MAX;
        rows_reg = COUNT_MAX;
        for (int k = 0; k < VEC_DEPTH; k++) vec_written[k] = 1'b0;

        // basic dot products
        directed_steps.push_back(reg_step(CFG_COLS, 13'd2));
        directed_steps.push_back(reg_step(CFG_ROWS, 13'd2));
        directed_steps.push_back(item_step(OP_LOAD, 12'd0, 32'h0001_0000));
        directed_steps.push_back(item_step(OP_LOAD, 12'd1, 32'h0002_0000));
        directed_steps.push_back(item_step(OP_LOAD, 12'd4095, 32'hFFFF_FFFF));
        directed_steps.push_back(item_step(OP_MATRIX, 12'hFFF, 32'h0001_0000));
        directed_steps.push_back(want_step(32'h0001_0000, 64'h0000_0003_0000_0000,
                                           12'd0, 1'b0, 1'b0));
        directed_steps.push_back(item_step(OP_MATRIX, 12'd0, 32'h0000_0000));
        directed_steps.push_back(want_step(32'h0000_0000, 64'd0, 12'd1, 1'b1, 1'b0));
        // positive clip
        directed_steps.push_back(item_step(OP_LOAD, 12'd0, 32'h8000_0000));
        directed_steps.push_back(item_step(OP_LOAD, 12'd1, 32'h8000_0000));
        directed_steps.push_back(item_step(OP_MATRIX, 12'd0, 32'h8000_0000));
        directed_steps.push_back(want_step(32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                                           12'd0, 1'b0, 1'b1));
        directed_steps.push_back(item_step(OP_MATRIX, 12'd0, 32'h7FFF_FFFF));
        directed_steps.push_back(item_step(OP_MATRIX, 12'd0, 32'h7FFF_FFFF));
        // a load in the middle of a row drops the partial sum
        directed_steps.push_back(item_step(OP_MATRIX, 12'd0, 32'h8000_0000));
        directed_steps.push_back(item_step(OP_LOAD, 12'd1, 32'h7FFF_FFFF));
        directed_steps.push_back(item_step(OP_MATRIX, 12'd0, 32'h0001_0000));
        directed_steps.push_back(item_step(OP_MATRIX, 12'd0, 32'h8000_0000));
        // zero counts act as one, spare indexes do nothing
        directed_steps.push_back(reg_step(CFG_COLS, 13'd0));
        directed_steps.push_back(reg_step(CFG_ROWS, 13'd1));
        directed_steps.push_back(reg_step(CFG_SPARE_2, COUNT_ALL1));
        directed_steps.push_back(reg_step(CFG_SPARE_3, COUNT_ALL1));
        directed_steps.push_back(item_step(OP_MATRIX, 12'd0, 32'hFFFF_FFFF));
        directed_steps.push_back(want_step(32'h8000_0000, 64'h4000_0000_0000_0000,
                                           12'd0, 1'b1, 1'b0));
        // negative clip
        directed_steps.push_back(reg_step(CFG_COLS, 13'd3));
        directed_steps.push_back(item_step(OP_LOAD, 12'd2, 32'h8000_0000));
        directed_steps.push_back(item_step(OP_LOAD, 12'd1, 32'h8000_0000));
        directed_steps.push_back(item_step(OP_MATRIX, 12'd0, 32'h7FFF_FFFF));
        directed_steps.push_back(item_step(OP_MATRIX, 12'd0, 32'h7FFF_FFFF));
        directed_steps.push_back(want_step(32'h7FFF_FFFF, 64'h8000_0000_0000_0000,
                                           12'd0, 1'b1, 1'b1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[n]) begin
            s = directed_steps[n];
            if (s.kind == STEP_REG) begin
                settle();
                write_reg(s.reg_idx, s.reg_data);
            end else begin
                send_item(s.op, s.idx, s.val, got, res);
                if (s.typed) pending_rows.push_back(s.want);
                else if (got) pending_rows.push_back(res);
            end
        end

        // wider rows with the row count above its maximum
        set_shape(WIDE_COLS, COUNT_ALL1);
        load_vector(int'(WIDE_COLS));
        repeat (4 * int'(WIDE_COLS)) random_item(0);

        // short rows with random shapes, occasional stray loads
        phase_start = loads_sent + mats_sent;
        while (loads_sent + mats_sent - phase_start < 1400) begin
            case ($urandom_range(0, 9))
                0: cols_w = 13'd0;
                1: cols_w = 13'd1;
                default: cols_w = 13'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 9))
                0: rows_w = 13'd0;
                1: rows_w = COUNT_ALL1;
                default: rows_w = 13'($urandom_range(1, 5));
            endcase
            set_shape(cols_w, rows_w);
            if ($urandom_range(0, 3) != 0) load_vector(int'(eff_count(cols_w)));
            repeat ($urandom_range(10, 80)) random_item(4);
        end

        // single-column rows past the last row and back to row zero
        set_shape(13'd1, SINGLE_ROWS);
        repeat (200) random_item(0);

        settle();
        repeat (20) @(posedge i_clk);
        $display("sent %0d loads and %0d matrix elements, column counts 1 to 64",
                 loads_sent, mats_sent);
        $display("checked %0d row sums, %0d of them clipped", rows_checked, rows_clipped);
        if (fail_count == 0) begin
            $display("matrix_vector_multiply_unit verification clean");
        end else begin
            $display("matrix_vector_multiply_unit verification failed");
        end
        $finish;
    end

endmodule
